// ----- rtl/grid_maze_dfs_generator_assert.svh -----
// assertion macros shared by the maze generator rtl
// no dependencies; the including module provides i_clk and i_rst_n
`ifndef GRID_MAZE_DFS_GENERATOR_ASSERT_SVH
`define GRID_MAZE_DFS_GENERATOR_ASSERT_SVH

// plain property checked every clock outside reset
`define GMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication checked every clock outside reset
`define GMD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/gmd_pkg.sv -----
// shared types and constants of the maze generator
// no dependencies
package gmd_pkg;

    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int RND_W         = 32;
    localparam int CELL_OUT_W    = 10;
    localparam int MAX_CELLS_DEF = 1024;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = 1'b1;

    // input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // remainder unit request and status
    typedef struct packed {
        logic start;
        logic short_op;
    } t_rem_req;

    typedef struct packed {
        logic busy;
    } t_rem_rsp;

endpackage

// ----- rtl/gmd_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module gmd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gmd_rem.sv -----
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on gmd_pkg (request and status structs, widths)
module gmd_rem
    import gmd_pkg::*;
#(
    parameter int SHORT_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_rem_req         i_req,
    input  logic [RND_W-1:0] i_dividend,
    input  logic [CFG_W-1:0] i_divisor,
    output t_rem_rsp         o_rsp,
    output logic [CFG_W-1:0] o_rem
);

    localparam int CNTW = $clog2(RND_W + 1);

    logic [CNTW-1:0]  r_cnt, n_cnt;
    logic [RND_W-1:0] r_dvd, n_dvd;
    logic [CFG_W-1:0] r_rem, n_rem;
    logic [CFG_W-1:0] r_dsr, n_dsr;
    logic [CFG_W:0]   w_trial;

    assign w_trial = {r_rem, r_dvd[RND_W-1]};

    always_comb begin
        n_cnt = r_cnt;
        n_dvd = r_dvd;
        n_rem = r_rem;
        n_dsr = r_dsr;
        if (i_req.start) begin
            // short mode left-aligns a narrow dividend so fewer steps are needed
            n_dvd = i_req.short_op ? (i_dividend << (RND_W - SHORT_BITS)) : i_dividend;
            n_cnt = i_req.short_op ? CNTW'(SHORT_BITS) : CNTW'(RND_W);
            n_rem = '0;
            n_dsr = i_divisor;
        end else if (r_cnt != '0) begin
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = CFG_W'(w_trial - {1'b0, r_dsr});
            end else begin
                n_rem = w_trial[CFG_W-1:0];
            end
            n_dvd = r_dvd << 1;
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rem      = r_rem;

endmodule

// ----- rtl/grid_maze_dfs_generator.sv -----
// start beat: the visited-map clearing sweep runs while the remainder unit finds the start cell
// step beat: per popped cell a stack read, the column remainder, the visited-bit reads and
//   the pick, then pushes of the current and next cell and the emitted passage
// one beat at a time: the block stalls its input until the result register takes the result
// reset (synchronous, active low): stack empty, cell_count 16, grid_width 4, no result
`include "grid_maze_dfs_generator_assert.svh"

module grid_maze_dfs_generator
    import gmd_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    input  logic [RND_W-1:0]      i_random_word,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_edge_valid,
    output logic [CELL_OUT_W-1:0] o_from_cell,
    output logic [CELL_OUT_W-1:0] o_to_cell,
    output logic                  o_done_res
);

    // cell index width, and a working width that holds any cell, count or sum of two
    localparam int CW = $clog2(MAX_CELLS);
    localparam int LW = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam int DW = CW + 1;
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_CELLS);
    localparam logic [CW-1:0] LAST_CELL = CW'(MAX_CELLS - 1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_CLR      = 11'b000_0000_0010,
        S_START_WR = 11'b000_0000_0100,
        S_POP      = 11'b000_0000_1000,
        S_POP_DATA = 11'b000_0001_0000,
        S_COL      = 11'b000_0010_0000,
        S_VRD      = 11'b000_0100_0000,
        S_PICK     = 11'b000_1000_0000,
        S_PUSH1    = 11'b001_0000_0000,
        S_PUSH2    = 11'b010_0000_0000,
        S_EMIT     = 11'b100_0000_0000
    } t_state;

    // residue mod 3 of a 32-bit word: nibble digits sum since 16 is 1 mod 3
    function automatic logic [1:0] mod3_32(input logic [RND_W-1:0] v);
        logic [6:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < RND_W / 4; i++) begin
            s = s + 7'(v[4*i +: 4]);
        end
        t = 4'(s[6]) + 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
        u = 3'(t[3:2]) + 3'(t[1:0]);
        return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

    // control registers
    t_state           r_state, n_state;
    logic [DW-1:0]    r_depth, n_depth;
    logic             r_out_valid, n_out_valid;
    logic [CFG_W-1:0] r_cell_count, n_cell_count;
    logic [CFG_W-1:0] r_grid_width, n_grid_width;
    logic             r_clr_run, n_clr_run;

    // working registers
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [1:0]       r_rnd_m3, n_rnd_m3;
    logic [CW-1:0]    r_clr, n_clr;
    logic [CW-1:0]    r_cur, n_cur;
    logic [3:0]       r_cand, n_cand;
    logic [CW-1:0]    r_nb [4];
    logic [CW-1:0]    n_nb [4];
    logic [3:0]       r_free, n_free;
    logic [2:0]       r_k, n_k;
    logic [CW-1:0]    r_next, n_next;
    logic             r_res_edge, n_res_edge;
    logic             r_res_done, n_res_done;
    logic [CW-1:0]    r_res_from, n_res_from;
    logic [CW-1:0]    r_res_to, n_res_to;
    logic             r_edge, n_edge;
    logic             r_done, n_done;
    logic [CW-1:0]    r_from, n_from;
    logic [CW-1:0]    r_to, n_to;

    // memory ports
    logic          v_we, v_wdata, v_rdata;
    logic [CW-1:0] v_waddr, v_raddr;
    logic          s_we;
    logic [CW-1:0] s_waddr, s_wdata, s_raddr, s_rdata;

    // remainder unit
    t_rem_req         w_rem_req;
    t_rem_rsp         w_rem_rsp;
    logic [RND_W-1:0] w_rem_dvd;
    logic [CFG_W-1:0] w_rem_dsr;
    logic [CFG_W-1:0] w_rem;

    // effective grid size: zero count or width act as one, count capped at the stack depth
    logic [LW-1:0]    w_n, w_w;
    logic [LW-1:0]    w_cur_l, w_rdata_l, w_rem_l;
    logic [CW-1:0]    w_start_cell;
    logic             w_accept, w_load;
    logic [1:0]       w_km1;
    logic [2:0]       w_cnt;
    logic [1:0]       w_sel;
    logic [1:0]       w_pick;
    logic [2:0]       w_seen;
    logic             w_found;

    always_comb begin
        if (r_cell_count == '0) begin
            w_n = LW'(1);
        end else if (LW'(r_cell_count) > LW'(MAX_CELLS)) begin
            w_n = LW'(MAX_CELLS);
        end else begin
            w_n = LW'(r_cell_count);
        end
        w_w = (r_grid_width == '0) ? LW'(1) : LW'(r_grid_width);
    end

    assign w_cur_l      = LW'(r_cur);
    assign w_rdata_l    = LW'(s_rdata);
    assign w_rem_l      = LW'(w_rem);
    assign w_start_cell = w_rem_l[CW-1:0];
    assign w_km1        = 2'(r_k - 3'd1);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    // result register takes a new beat when empty or being drained
    assign w_load     = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    // neighbour choice: the random word picks among the free neighbours in list order
    always_comb begin
        w_cnt = 3'($countones(r_free));
        unique case (w_cnt)
            3'd2:    w_sel = {1'b0, r_rnd[0]};
            3'd3:    w_sel = r_rnd_m3;
            3'd4:    w_sel = r_rnd[1:0];
            default: w_sel = 2'd0;
        endcase
        w_pick  = 2'd0;
        w_seen  = 3'd0;
        w_found = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (r_free[j]) begin
                if (!w_found && (w_seen == {1'b0, w_sel})) begin
                    w_pick  = 2'(j);
                    w_found = 1'b1;
                end
                w_seen = w_seen + 3'd1;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_cell_count = r_cell_count;
        n_grid_width = r_grid_width;
        n_clr_run    = r_clr_run;
        n_rnd        = r_rnd;
        n_rnd_m3     = r_rnd_m3;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_cand       = r_cand;
        n_nb         = r_nb;
        n_free       = r_free;
        n_k          = r_k;
        n_next       = r_next;
        n_res_edge   = r_res_edge;
        n_res_done   = r_res_done;
        n_res_from   = r_res_from;
        n_res_to     = r_res_to;
        n_edge       = r_edge;
        n_done       = r_done;
        n_from       = r_from;
        n_to         = r_to;
        n_out_valid  = r_out_valid && i_out_stall;

        v_we    = 1'b0;
        v_waddr = r_clr;
        v_wdata = 1'b0;
        v_raddr = r_nb[r_k[1:0]];
        s_we    = 1'b0;
        s_waddr = r_depth[CW-1:0];
        s_wdata = r_cur;
        s_raddr = CW'(r_depth - DW'(1));

        w_rem_req.start    = 1'b0;
        w_rem_req.short_op = 1'b0;
        w_rem_dvd          = r_rnd;
        w_rem_dsr          = w_n[CFG_W-1:0];

        // config writes must arrive only while idle; the block itself does not enforce it
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CELL_COUNT: n_cell_count = i_cfg_data;
                CFG_GRID_WIDTH: n_grid_width = i_cfg_data;
                default:        n_cell_count = r_cell_count;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rnd    = i_random_word;
                    n_rnd_m3 = mod3_32(i_random_word);
                    if (i_command == CMD_START) begin
                        // start cell = random mod n while the map is swept clear
                        w_rem_req.start = 1'b1;
                        w_rem_dvd       = i_random_word;
                        n_clr           = '0;
                        n_clr_run       = 1'b1;
                        n_state         = S_CLR;
                    end else begin
                        n_state = S_POP;
                    end
                end
            end
            S_CLR: begin
                if (r_clr_run) begin
                    v_we    = 1'b1;
                    v_waddr = r_clr;
                    v_wdata = 1'b0;
                    if (r_clr == LAST_CELL) begin
                        n_clr_run = 1'b0;
                    end else begin
                        n_clr = r_clr + CW'(1);
                    end
                end else if (!w_rem_rsp.busy) begin
                    n_state = S_START_WR;
                end
            end
            S_START_WR: begin
                // mark and push the start cell on a fresh stack
                v_we       = 1'b1;
                v_waddr    = w_start_cell;
                v_wdata    = 1'b1;
                s_we       = 1'b1;
                s_waddr    = '0;
                s_wdata    = w_start_cell;
                n_depth    = DW'(1);
                n_res_edge = 1'b0;
                n_res_done = 1'b0;
                n_res_from = w_start_cell;
                n_res_to   = w_start_cell;
                n_state    = S_EMIT;
            end
            S_POP: begin
                if (r_depth == '0) begin
                    // stack ran dry: maze complete
                    n_res_edge = 1'b0;
                    n_res_done = 1'b1;
                    n_res_from = '0;
                    n_res_to   = '0;
                    n_state    = S_EMIT;
                end else begin
                    s_raddr = CW'(r_depth - DW'(1));
                    n_depth = r_depth - DW'(1);
                    n_state = S_POP_DATA;
                end
            end
            S_POP_DATA: begin
                n_cur = s_rdata;
                if (w_rdata_l >= w_n) begin
                    // cell lies outside the current grid: dead end
                    n_state = S_POP;
                end else begin
                    // column = cell mod width
                    w_rem_req.start    = 1'b1;
                    w_rem_req.short_op = 1'b1;
                    w_rem_dvd          = RND_W'(s_rdata);
                    w_rem_dsr          = w_w[CFG_W-1:0];
                    n_state            = S_COL;
                end
            end
            S_COL: begin
                if (!w_rem_rsp.busy) begin
                    // candidates in order: up, down, left, right
                    n_cand[0] = (w_cur_l >= w_w);
                    n_cand[1] = ((w_cur_l + w_w) < w_n);
                    n_cand[2] = (w_rem != '0);
                    n_cand[3] = (w_rem_l != (w_w - LW'(1))) && ((w_cur_l + LW'(1)) != w_n);
                    n_nb[0]   = CW'(w_cur_l - w_w);
                    n_nb[1]   = CW'(w_cur_l + w_w);
                    n_nb[2]   = CW'(w_cur_l - LW'(1));
                    n_nb[3]   = CW'(w_cur_l + LW'(1));
                    n_free    = '0;
                    n_k       = '0;
                    n_state   = S_VRD;
                end
            end
            S_VRD: begin
                // read one visited bit a cycle, check the previous one's data
                v_raddr = r_nb[r_k[1:0]];
                if (r_k != 3'd0) begin
                    n_free[w_km1] = r_cand[w_km1] && !v_rdata;
                end
                if (r_k == 3'd4) begin
                    n_state = S_PICK;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_PICK: begin
                if (w_cnt == 3'd0) begin
                    n_state = S_POP;
                end else begin
                    v_we    = 1'b1;
                    v_waddr = r_nb[w_pick];
                    v_wdata = 1'b1;
                    n_next  = r_nb[w_pick];
                    n_state = S_PUSH1;
                end
            end
            S_PUSH1: begin
                // pushes beyond the stack depth are dropped
                if (r_depth < DEPTH_MAX) begin
                    s_we    = 1'b1;
                    s_waddr = r_depth[CW-1:0];
                    s_wdata = r_cur;
                    n_depth = r_depth + DW'(1);
                end
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                if (r_depth < DEPTH_MAX) begin
                    s_we    = 1'b1;
                    s_waddr = r_depth[CW-1:0];
                    s_wdata = r_next;
                    n_depth = r_depth + DW'(1);
                end
                n_res_edge = 1'b1;
                n_res_done = 1'b0;
                n_res_from = r_cur;
                n_res_to   = r_next;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_edge      = r_res_edge;
                    n_done      = r_res_done;
                    n_from      = r_res_from;
                    n_to        = r_res_to;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
            r_cell_count <= CFG_W'(16);
            r_grid_width <= CFG_W'(4);
            r_clr_run    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_depth      <= n_depth;
            r_out_valid  <= n_out_valid;
            r_cell_count <= n_cell_count;
            r_grid_width <= n_grid_width;
            r_clr_run    <= n_clr_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rnd      <= n_rnd;
        r_rnd_m3   <= n_rnd_m3;
        r_clr      <= n_clr;
        r_cur      <= n_cur;
        r_cand     <= n_cand;
        r_nb       <= n_nb;
        r_free     <= n_free;
        r_k        <= n_k;
        r_next     <= n_next;
        r_res_edge <= n_res_edge;
        r_res_done <= n_res_done;
        r_res_from <= n_res_from;
        r_res_to   <= n_res_to;
        r_edge     <= n_edge;
        r_done     <= n_done;
        r_from     <= n_from;
        r_to       <= n_to;
    end

    // visited map: one bit per cell
    gmd_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    // backtracking stack of cell indexes
    gmd_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_CELLS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // shared remainder unit: start cell and column of a popped cell
    gmd_rem #(
        .SHORT_BITS (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_rem_req),
        .i_dividend (w_rem_dvd),
        .i_divisor  (w_rem_dsr),
        .o_rsp      (w_rem_rsp),
        .o_rem      (w_rem)
    );

    // output cells carry the low bits of the cell index
    logic [LW-1:0] w_from_l, w_to_l;
    assign w_from_l     = LW'(r_from);
    assign w_to_l       = LW'(r_to);
    assign o_out_valid  = r_out_valid;
    assign o_edge_valid = r_edge;
    assign o_done_res   = r_done;
    assign o_from_cell  = w_from_l[CELL_OUT_W-1:0];
    assign o_to_cell    = w_to_l[CELL_OUT_W-1:0];

    `GMD_ASSERT(a_depth_bound, r_depth <= DEPTH_MAX, "stack depth beyond capacity")
    `GMD_ASSERT_IMPLIES(a_edge_done_excl, o_out_valid, !(o_edge_valid && o_done_res),
        "result beat marks both passage and done")
    `GMD_ASSERT_IMPLIES(a_rem_start_idle, w_rem_req.start, !w_rem_rsp.busy,
        "remainder unit restarted while busy")

endmodule
